FILE: rtl/core/yhpd_pkg.sv
// Shared types and constants for the yaw heading PD controller.
`default_nettype none
package yhpd_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned DT_W      = 16;
	localparam int unsigned GAIN_W    = 32;
	localparam int unsigned GAIN_FRAC = 16;
	localparam int unsigned MUL_A_W   = WORD_W + 1;
	localparam int unsigned MUL_HI_W  = WORD_W + 2;
	localparam int unsigned SUM_W     = MUL_HI_W + WORD_W - GAIN_FRAC;
	localparam int unsigned CNT_W     = $clog2(GAIN_W);
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P      = 3'd0,
		CFG_GAIN_D      = 3'd1,
		CFG_DRIVE_UPPER = 3'd2,
		CFG_DRIVE_LOWER = 3'd3,
		CFG_STEP_TIME   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic                     mode;
		logic signed [WORD_W-1:0] stick_yaw;
		logic signed [WORD_W-1:0] measured_yaw;
		logic signed [WORD_W-1:0] yaw_rate_in;
		logic signed [WORD_W-1:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] drive;
		logic signed [WORD_W-1:0] heading_target;
		logic signed [WORD_W-1:0] heading_error;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic run;
	} mul_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/yhpd_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
`default_nettype none
interface yhpd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/yhpd_serial_mul.sv
// Bit-serial signed by unsigned shift-add multiplier, one multiplier bit per cycle while run is set.
`default_nettype none
module yhpd_serial_mul (
	input  logic                                     clk,
	input  yhpd_pkg::mul_ctrl_t                      ctrl,
	input  logic signed [yhpd_pkg::MUL_A_W-1:0]      a,
	input  logic        [yhpd_pkg::GAIN_W-1:0]       b,
	output logic signed [yhpd_pkg::MUL_HI_W-1:0]     hi,
	output logic        [yhpd_pkg::WORD_W-1:0]       lo
);
	import yhpd_pkg::*;

	logic signed [MUL_A_W-1:0]  a_q;
	logic        [GAIN_W-1:0]   b_q;
	logic signed [MUL_HI_W-1:0] hi_q;
	logic        [WORD_W-1:0]   lo_q;
	logic signed [MUL_HI_W-1:0] addend;
	logic signed [MUL_HI_W-1:0] sum;

	// partial product kept as {hi, lo}; hi is always the floor of the value so far
	assign addend = b_q[0] ? {{(MUL_HI_W-MUL_A_W){a_q[MUL_A_W-1]}}, a_q} : '0;
	assign sum    = hi_q + addend;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (ctrl.run) begin
			hi_q <= {sum[MUL_HI_W-1], sum[MUL_HI_W-1:1]};
			lo_q <= {sum[0], lo_q[WORD_W-1:1]};
			b_q  <= {1'b0, b_q[GAIN_W-1:1]};
		end
	end

	assign hi = hi_q;
	assign lo = lo_q;
endmodule
`default_nettype wire

FILE: rtl/core/yaw_heading_pd_controller.sv
// Yaw heading PD controller top level: config registers, sequencer, output register.
// Sequence: a setpoint load beat goes straight to ST_FINISH; a control step beat
// runs ST_STICK (16 serial steps for stick*dt), ST_SETPT, ST_WRAP, ST_ERR, ST_PROD
// (32 for the gains), ST_SUM, ST_CLAMP and ST_FINISH. No new beat is taken before the
// last result is registered. Input ready only while the sequencer is idle.
// Reset (arst_n low, asynchronous): setpoint, gains, limits and step time cleared.
`default_nettype none
module yaw_heading_pd_controller #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [yhpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [yhpd_pkg::WORD_W-1:0]       cfg_data,
	yhpd_stream_if.sink                       in_ch,
	yhpd_stream_if.source                     out_ch
);
	import yhpd_pkg::*;

	localparam int SP_W = WORD_W + 4;
	localparam logic signed [SP_W-1:0] DEADBAND  = SP_W'(5) << FRAC_BITS;
	localparam logic signed [SP_W-1:0] HALF_TURN = SP_W'(180) << FRAC_BITS;
	localparam logic signed [SP_W-1:0] FULL_TURN = SP_W'(360) << FRAC_BITS;
	localparam logic signed [SP_W-1:0] NEG_DEADBAND  = -DEADBAND;
	localparam logic signed [SP_W-1:0] NEG_HALF_TURN = -HALF_TURN;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STICK,
		ST_SETPT,
		ST_WRAP,
		ST_ERR,
		ST_PROD,
		ST_SUM,
		ST_CLAMP,
		ST_FINISH
	} state_t;

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SP_W-1:0] v);
		logic [SP_W-WORD_W:0] hi_bits;
		hi_bits = v[SP_W-1:WORD_W-1];
		if ((&hi_bits) || (~|hi_bits))
			return v[WORD_W-1:0];
		else if (v[SP_W-1])
			return {1'b1, {(WORD_W-1){1'b0}}};
		else
			return {1'b0, {(WORD_W-1){1'b1}}};
	endfunction

	// configuration registers
	logic        [GAIN_W-1:0] gain_p_q;
	logic        [GAIN_W-1:0] gain_d_q;
	logic signed [WORD_W-1:0] upper_q;
	logic signed [WORD_W-1:0] lower_q;
	logic        [DT_W-1:0]   step_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_d_q    <= '0;
			upper_q     <= '0;
			lower_q     <= '0;
			step_time_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GAIN_P:      gain_p_q    <= cfg_data;
				CFG_GAIN_D:      gain_d_q    <= cfg_data;
				CFG_DRIVE_UPPER: upper_q     <= cfg_data;
				CFG_DRIVE_LOWER: lower_q     <= cfg_data;
				CFG_STEP_TIME:   step_time_q <= cfg_data[DT_W-1:0];
				default: ;
			endcase
		end
	end

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     move_q;
	logic signed [WORD_W-1:0] yaw_q;
	logic signed [WORD_W-1:0] target_q;
	logic signed [SP_W-1:0]   sp_q;
	logic signed [WORD_W-1:0] err_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [WORD_W-1:0] drive_q;
	out_item_t                out_q;
	logic                     out_valid_q;

	logic                       accept;
	logic signed [SP_W-1:0]     stick_ext;
	logic                       outside_db;
	logic signed [SP_W-1:0]     err_diff;
	logic signed [WORD_W-1:0]   err_c;
	logic signed [SP_W-1:0]     sp_sum;
	logic signed [SP_W-1:0]     sp_wrapped;
	logic signed [SUM_W-1:0]    p_term;
	logic signed [SUM_W-1:0]    d_term;
	logic signed [SUM_W-1:0]    sum_c;
	logic signed [SUM_W-1:0]    upper_ext;
	logic signed [SUM_W-1:0]    lower_ext;
	logic signed [WORD_W-1:0]   drive_c;

	mul_ctrl_t                  mul0_ctrl;
	mul_ctrl_t                  mul1_ctrl;
	logic signed [MUL_A_W-1:0]  mul0_a;
	logic signed [MUL_A_W-1:0]  mul1_a;
	logic        [GAIN_W-1:0]   mul0_b;
	logic signed [MUL_HI_W-1:0] mul0_hi;
	logic signed [MUL_HI_W-1:0] mul1_hi;
	logic        [WORD_W-1:0]   mul0_lo;
	logic        [WORD_W-1:0]   mul1_lo;

	assign accept       = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	assign stick_ext  = {{(SP_W-WORD_W){in_ch.data.stick_yaw[WORD_W-1]}}, in_ch.data.stick_yaw};
	assign outside_db = (stick_ext > DEADBAND) || (stick_ext < NEG_DEADBAND);

	assign err_diff = {{(SP_W-WORD_W){target_q[WORD_W-1]}}, target_q}
		- {{(SP_W-WORD_W){yaw_q[WORD_W-1]}}, yaw_q};
	assign err_c    = sat_word(err_diff);

	assign sp_sum = {{(SP_W-WORD_W){target_q[WORD_W-1]}}, target_q}
		+ {{(SP_W-MUL_HI_W){mul0_hi[MUL_HI_W-1]}}, mul0_hi};

	always_comb begin
		priority if (sp_q > HALF_TURN)
			sp_wrapped = sp_q - FULL_TURN;
		else if (sp_q < NEG_HALF_TURN)
			sp_wrapped = sp_q + FULL_TURN;
		else
			sp_wrapped = sp_q;
	end

	// floor shift by the gain fraction is a bit-select of the full product
	assign p_term = {mul0_hi, mul0_lo[WORD_W-1:GAIN_FRAC]};
	assign d_term = {mul1_hi, mul1_lo[WORD_W-1:GAIN_FRAC]};
	assign sum_c  = p_term + d_term;

	assign upper_ext = {{(SUM_W-WORD_W){upper_q[WORD_W-1]}}, upper_q};
	assign lower_ext = {{(SUM_W-WORD_W){lower_q[WORD_W-1]}}, lower_q};

	always_comb begin
		priority if (sum_q > upper_ext)
			drive_c = upper_q;
		else if (sum_q < lower_ext)
			drive_c = lower_q;
		else
			drive_c = sum_q[WORD_W-1:0];
	end

	// mul0: stick*dt over DT_W steps, then gain_p*error; mul1: gain_d*(-rate)
	always_comb begin
		mul0_ctrl.load = (accept && !in_ch.data.mode) || (state_q == ST_ERR);
		mul0_ctrl.run  = (state_q == ST_STICK) || (state_q == ST_PROD);
		mul1_ctrl.load = accept && !in_ch.data.mode;
		mul1_ctrl.run  = (state_q == ST_PROD);
		if (state_q == ST_ERR) begin
			mul0_a = {err_c[WORD_W-1], err_c};
			mul0_b = gain_p_q;
		end else begin
			mul0_a = {in_ch.data.stick_yaw[WORD_W-1], in_ch.data.stick_yaw};
			mul0_b = {{(GAIN_W-DT_W){1'b0}}, step_time_q};
		end
		mul1_a = -{in_ch.data.yaw_rate_in[WORD_W-1], in_ch.data.yaw_rate_in};
	end

	yhpd_serial_mul u_mul_p (
		.clk  (clk),
		.ctrl (mul0_ctrl),
		.a    (mul0_a),
		.b    (mul0_b),
		.hi   (mul0_hi),
		.lo   (mul0_lo)
	);

	yhpd_serial_mul u_mul_d (
		.clk  (clk),
		.ctrl (mul1_ctrl),
		.a    (mul1_a),
		.b    (gain_d_q),
		.hi   (mul1_hi),
		.lo   (mul1_lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			move_q      <= 1'b0;
			yaw_q       <= '0;
			target_q    <= '0;
			sp_q        <= '0;
			err_q       <= '0;
			sum_q       <= '0;
			drive_q     <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready && (state_q != ST_FINISH))
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						yaw_q <= in_ch.data.measured_yaw;
						cnt_q <= '0;
						if (in_ch.data.mode) begin
							target_q <= in_ch.data.load_value;
							err_q    <= '0;
							drive_q  <= '0;
							state_q  <= ST_FINISH;
						end else begin
							move_q  <= outside_db;
							state_q <= ST_STICK;
						end
					end
				end
				ST_STICK: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DT_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SETPT;
					end
				end
				ST_SETPT: begin
					sp_q    <= sp_sum;
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					if (move_q)
						target_q <= sat_word(sp_wrapped);
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					err_q   <= err_c;
					state_q <= ST_PROD;
				end
				ST_PROD: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(GAIN_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					sum_q   <= sum_c;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					drive_q <= drive_c;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ch.ready) begin
						out_q.drive          <= drive_q;
						out_q.heading_target <= target_q;
						out_q.heading_error  <= err_q;
						out_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for the yaw heading PD controller: directed and random beats checked by a predictor.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import yhpd_pkg::*;

	localparam int     FRAC      = 16;
	localparam int     DEG       = 1 << FRAC;
	localparam longint DEADBAND  = longint'(5) <<< FRAC;
	localparam longint HALF_TURN = longint'(180) <<< FRAC;
	localparam longint FULL_TURN = longint'(360) <<< FRAC;
	localparam int     S32_MAX   = 32'h7fff_ffff;
	localparam int     S32_MIN   = 32'h8000_0000;
	localparam int     MAX_QUIET = 4000;
	localparam int     LONG_HOLD = 400;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data  = '0;

	yhpd_stream_if #(.T(in_item_t))  in_ch ();
	yhpd_stream_if #(.T(out_item_t)) out_ch ();

	yaw_heading_pd_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// predictor copy of the registers and the setpoint
	logic [31:0] kp_q       = '0;
	logic [31:0] kd_q       = '0;
	int          drive_hi_q = 0;
	int          drive_lo_q = 0;
	logic [15:0] dt_q       = '0;
	int          setpoint_q = 0;

	out_item_t pending_results[$];
	int        n_fail     = 0;
	bit        gaps_on    = 1'b1;
	int        hold_off   = 0;
	int        stall_left = 0;
	int        quiet      = 0;

	always begin
		#2ns clk = 1'b1;
		#2ns clk = 1'b0;
	end

	function automatic int clip32(longint v);
		if (v > longint'(S32_MAX))
			return S32_MAX;
		if (v < longint'(S32_MIN))
			return S32_MIN;
		return int'(v);
	endfunction

	function automatic out_item_t step_heading(in_item_t beat);
		out_item_t r;
		longint    stick, yaw, rate, dt, kp, kd, sp, drv;
		int        err;
		stick = $signed(beat.stick_yaw);
		yaw   = $signed(beat.measured_yaw);
		rate  = $signed(beat.yaw_rate_in);
		dt    = dt_q;
		kp    = kp_q;
		kd    = kd_q;
		if (beat.mode) begin
			setpoint_q       = $signed(beat.load_value);
			r.drive          = '0;
			r.heading_target = beat.load_value;
			r.heading_error  = '0;
			return r;
		end
		if (stick > DEADBAND || stick < -DEADBAND) begin
			sp = longint'(setpoint_q) + ((stick * dt) >>> FRAC);
			if (sp > HALF_TURN)
				sp -= FULL_TURN;
			else if (sp < -HALF_TURN)
				sp += FULL_TURN;
			setpoint_q = clip32(sp);
		end
		err = clip32(longint'(setpoint_q) - yaw);
		drv = ((kp * longint'(err)) >>> GAIN_FRAC) + ((kd * -rate) >>> GAIN_FRAC);
		if (drv > longint'(drive_hi_q))
			drv = drive_hi_q;
		else if (drv < longint'(drive_lo_q))
			drv = drive_lo_q;
		r.drive          = drv[31:0];
		r.heading_target = setpoint_q;
		r.heading_error  = err;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
			n_fail++;
		end
	endtask

	// result checker
	always @(posedge clk) begin : chk
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: drive %0d",
					$signed(out_ch.data.drive));
				n_fail++;
			end else begin
				want = pending_results.pop_front();
				check_field("drive", want.drive, out_ch.data.drive);
				check_field("heading_target", want.heading_target, out_ch.data.heading_target);
				check_field("heading_error", want.heading_error, out_ch.data.heading_error);
			end
		end
	end

	// result sink: random stall bursts plus the long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= MAX_QUIET) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_item(in_item_t beat);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= beat;
		do @(posedge clk); while (!in_ch.ready);
		pending_results.push_back(step_heading(beat));
	endtask

	task automatic wait_results_done();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic apply_settings(logic [31:0] kp, logic [31:0] kd, logic [31:0] hi,
		logic [31:0] lo, logic [15:0] dt);
		cfg_idx_t idx;
		wait_results_done();
		idx = idx.first();
		repeat (idx.num()) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			case (idx)
				CFG_GAIN_P:      cfg_data <= kp;
				CFG_GAIN_D:      cfg_data <= kd;
				CFG_DRIVE_UPPER: cfg_data <= hi;
				CFG_DRIVE_LOWER: cfg_data <= lo;
				CFG_STEP_TIME:   cfg_data <= {16'h0, dt};
				default:         cfg_data <= '0;
			endcase
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		kp_q       = kp;
		kd_q       = kd;
		drive_hi_q = hi;
		drive_lo_q = lo;
		dt_q       = dt;
	endtask

	function automatic in_item_t mk_step(logic [31:0] stick, logic [31:0] yaw, logic [31:0] rate);
		in_item_t beat;
		beat.mode         = 1'b0;
		beat.stick_yaw    = stick;
		beat.measured_yaw = yaw;
		beat.yaw_rate_in  = rate;
		beat.load_value   = '0;
		return beat;
	endfunction

	function automatic in_item_t mk_load(logic [31:0] value);
		in_item_t beat;
		beat            = '0;
		beat.mode       = 1'b1;
		beat.load_value = value;
		return beat;
	endfunction

	function automatic logic [31:0] pick_angle();
		case ($urandom_range(0, 9))
			0:       return S32_MAX;
			1:       return S32_MIN;
			2, 3:    return $urandom;
			default: return $urandom_range(0, 400 * DEG) - 200 * DEG;
		endcase
	endfunction

	function automatic logic [31:0] pick_stick();
		case ($urandom_range(0, 9))
			0:       return $urandom_range(0, 1) ? 5 * DEG : -5 * DEG;
			1:       return $urandom_range(0, 1) ? 5 * DEG + 1 : -5 * DEG - 1;
			2:       return $urandom;
			3:       return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
			4:       return $urandom_range(0, 10 * DEG) - 5 * DEG;
			default: return $urandom_range(0, 400 * DEG) - 200 * DEG;
		endcase
	endfunction

	function automatic in_item_t pick_item();
		in_item_t beat;
		beat.mode         = ($urandom_range(0, 7) == 0);
		beat.stick_yaw    = pick_stick();
		beat.measured_yaw = pick_angle();
		beat.yaw_rate_in  = pick_angle();
		beat.load_value   = pick_angle();
		return beat;
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return $urandom;
			default: return $urandom_range(0, 4 * DEG);
		endcase
	endfunction

	task automatic randomize_settings();
		logic [31:0] hi, lo;
		logic [15:0] dt;
		int          span;
		span = $urandom_range(1, 3000) * DEG;
		case ($urandom_range(0, 5))
			0:       begin hi = S32_MAX; lo = S32_MIN; end
			1:       begin hi = -span / 4; lo = span / 4; end
			2:       begin hi = $urandom; lo = $urandom; end
			default: begin hi = span; lo = -span; end
		endcase
		case ($urandom_range(0, 5))
			0:       dt = '0;
			1:       dt = '1;
			2:       dt = 16'($urandom);
			default: dt = 16'($urandom_range(16'h0040, 16'h1000));
		endcase
		apply_settings(pick_gain(), pick_gain(), hi, lo, dt);
	endtask

	task automatic test_reset_state();
		send_item(mk_step(100 * DEG, 10 * DEG, 3 * DEG));
		send_item(mk_step(-100 * DEG, -10 * DEG, S32_MIN));
	endtask

	task automatic test_edge_cases();
		apply_settings(DEG, DEG / 2, 1000 * DEG, -1000 * DEG, 16'h0ccd);
		send_item(mk_load('0));
		send_item(mk_step(5 * DEG, DEG, 0));
		send_item(mk_step(-5 * DEG, -DEG, 0));
		send_item(mk_step(5 * DEG + 1, 0, 0));
		send_item(mk_step(-5 * DEG - 1, 0, 0));
		send_item(mk_load(179 * DEG));
		send_item(mk_step(100 * DEG, 0, 0));
		send_item(mk_load(-179 * DEG));
		send_item(mk_step(-100 * DEG, 0, 0));
		send_item(mk_load(S32_MAX));
		send_item(mk_step(0, S32_MIN, S32_MIN));
		send_item(mk_load(S32_MIN));
		send_item(mk_step(0, S32_MAX, S32_MAX));
		apply_settings('1, '1, S32_MAX, S32_MIN, 16'hffff);
		send_item(mk_load(S32_MAX));
		send_item(mk_step(S32_MAX, S32_MIN, S32_MIN));
		send_item(mk_load(S32_MIN));
		send_item(mk_step(S32_MIN, S32_MAX, S32_MAX));
		send_item(mk_step(0, 0, 0));
	endtask

	task automatic test_crossed_limits();
		apply_settings(DEG, '0, -10 * DEG, 10 * DEG, '0);
		send_item(mk_load('0));
		send_item(mk_step(0, -50 * DEG, 0));
		send_item(mk_step(0, 50 * DEG, 0));
		send_item(mk_step(0, 0, 0));
	endtask

	task automatic test_setting_sweep();
		apply_settings('0, '0, S32_MAX, S32_MIN, '0);
		repeat (40) send_item(pick_item());
		apply_settings('1, '1, S32_MAX, S32_MIN, '1);
		repeat (40) send_item(pick_item());
		apply_settings('1, '0, S32_MIN, S32_MAX, '1);
		repeat (40) send_item(pick_item());
		apply_settings('0, '1, '0, '0, 16'h0001);
		repeat (40) send_item(pick_item());
		apply_settings(2 * DEG, DEG / 4, 500 * DEG, -500 * DEG, 16'h0ccd);
		repeat (40) send_item(pick_item());
	endtask

	task automatic test_backpressure();
		randomize_settings();
		hold_off = LONG_HOLD;
		repeat (60) send_item(pick_item());
	endtask

	task automatic test_sender_pause();
		repeat (20) send_item(pick_item());
		wait_results_done();
		repeat (20) send_item(pick_item());
	endtask

	task automatic test_random_run();
		repeat (10) begin
			randomize_settings();
			repeat (125) send_item(pick_item());
		end
	endtask

	task automatic test_quiet_tail();
		randomize_settings();
		gaps_on = 1'b0;
		repeat (150) send_item(pick_item());
	endtask

	initial begin
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_edge_cases();
		test_crossed_limits();
		test_setting_sweep();
		test_backpressure();
		test_sender_pause();
		test_random_run();
		test_quiet_tail();

		wait_results_done();
		repeat (60) @(posedge clk);
		if (n_fail == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

FILE: yaw_heading_pd_controller.f
rtl/core/yhpd_pkg.sv
rtl/core/yhpd_stream_if.sv
rtl/core/yhpd_serial_mul.sv
rtl/core/yaw_heading_pd_controller.sv
tb/tb_top.sv
